FILE: src/tbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbd_pkg
// Types, constants and helpers shared by the TEA block decrypt unit.
// ----------------------------------------------------------------------------
package tbd_pkg;

	localparam int unsigned ROUNDS     = 32;
	localparam int unsigned CELLS      = 2 * ROUNDS;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned KEY_WORDS  = 4;
	localparam int unsigned KEY_IDX_W  = $clog2(KEY_WORDS);

	localparam logic [WORD_W-1:0] DELTA = 32'h9E3779B9;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [KEY_IDX_W-1:0] {
		KEY_WORD_0 = 2'd0,
		KEY_WORD_1 = 2'd1,
		KEY_WORD_2 = 2'd2,
		KEY_WORD_3 = 2'd3
	} key_index_t;

	typedef struct packed {
		word_t k3;
		word_t k2;
		word_t k1;
		word_t k0;
	} key_t;

	typedef struct packed {
		word_t cipher_first;
		word_t cipher_second;
	} cipher_t;

	typedef struct packed {
		word_t plain_first;
		word_t plain_second;
	} plain_t;

	// Word pair moving down the cell chain: x is the word just produced,
	// y is the word the next cell updates.
	typedef struct packed {
		word_t x;
		word_t y;
	} pair_t;

	// Running sum for round r: DELTA * (ROUNDS - r) modulo 2^32.
	function automatic word_t round_sum(input int unsigned r);
		logic [2*WORD_W-1:0] prod;
		prod = {{WORD_W{1'b0}}, DELTA} * (2*WORD_W)'(ROUNDS - r);
		return prod[WORD_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: src/tbd_key_file.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbd_key_file
// Four 32-bit key registers loaded through the configuration write port.
// ----------------------------------------------------------------------------
module tbd_key_file
	import tbd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [KEY_IDX_W-1:0] cfg_index,
	input  wire word_t                cfg_data,
	output key_t                      key
);

	key_t key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_write) begin
			case (key_index_t'(cfg_index))
				KEY_WORD_0: key_q.k0 <= cfg_data;
				KEY_WORD_1: key_q.k1 <= cfg_data;
				KEY_WORD_2: key_q.k2 <= cfg_data;
				KEY_WORD_3: key_q.k3 <= cfg_data;
				default: key_q <= key_q;
			endcase
		end
	end

	assign key = key_q;

endmodule
`default_nettype wire

FILE: src/tbd_round_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbd_round_cell
// One half round of TEA decryption with its own pipeline register.
// Updates y from x, then hands the pair on swapped.
// ----------------------------------------------------------------------------
module tbd_round_cell
	import tbd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire word_t sum,
	input  wire word_t ka,
	input  wire word_t kb,
	input  wire logic  prev_valid,
	output logic       prev_ready,
	input  wire pair_t prev_data,
	output logic       next_valid,
	input  wire logic  next_ready,
	output pair_t      next_data
);

	logic  valid_q;
	pair_t data_q;
	word_t mix;

	assign mix = ((prev_data.x << 4) + ka) ^ (prev_data.x + sum) ^ ((prev_data.x >> 5) + kb);

	// take a new request whenever this slot is empty or is draining this cycle
	assign prev_ready = !valid_q || next_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (prev_ready) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prev_ready && prev_valid) begin
			data_q.x <= prev_data.y - mix;
			data_q.y <= prev_data.x;
		end
	end

	assign next_valid = valid_q;
	assign next_data  = data_q;

endmodule
`default_nettype wire

FILE: src/tea_block_decrypt_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tea_block_decrypt_unit
// TEA decryption of 64-bit blocks under a 128-bit key, as a chain of
// half-round cells.
//
//   channel   direction  handshake                   payload
//   cipher    in         cipher_valid / cipher_stall cipher_t
//   plain     out        plain_valid / plain_stall   plain_t
//   cfg       in         cfg_write                   cfg_index, cfg_data
//
// One block is accepted per cycle while cipher_stall is low; each passes
// through 2*ROUNDS (64) half-round cells, each with its own register.
// The last cell register is the output register; each cell stalls on its
// own, so bubbles close up; while a result waits, input fills free cells.
// Reset clears all valid bits and the key to zero; no clearing pass.
// ----------------------------------------------------------------------------
module tea_block_decrypt_unit
	import tbd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cipher_valid,
	output logic                      cipher_stall,
	input  wire cipher_t              cipher,
	output logic                      plain_valid,
	input  wire logic                 plain_stall,
	output plain_t                    plain,
	input  wire logic                 cfg_write,
	input  wire logic [KEY_IDX_W-1:0] cfg_index,
	input  wire word_t                cfg_data
);

	key_t  key;
	logic  valid_c [CELLS+1];
	logic  ready_c [CELLS+1];
	pair_t data_c  [CELLS+1];

	tbd_key_file u_key_file (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key       (key)
	);

	assign valid_c[0]   = cipher_valid;
	assign data_c[0].x  = cipher.cipher_first;
	assign data_c[0].y  = cipher.cipher_second;
	assign cipher_stall = !ready_c[0];

	for (genvar c = 0; c < CELLS; c++) begin : g_cell
		localparam word_t SUM = round_sum(c / 2);
		// even cells update the second word, odd cells the first
		localparam bit UPD_FIRST = (c % 2) == 1;

		tbd_round_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.sum        (SUM),
			.ka         (UPD_FIRST ? key.k0 : key.k2),
			.kb         (UPD_FIRST ? key.k1 : key.k3),
			.prev_valid (valid_c[c]),
			.prev_ready (ready_c[c]),
			.prev_data  (data_c[c]),
			.next_valid (valid_c[c+1]),
			.next_ready (ready_c[c+1]),
			.next_data  (data_c[c+1])
		);
	end

	assign ready_c[CELLS]     = !plain_stall;
	assign plain_valid        = valid_c[CELLS];
	assign plain.plain_first  = data_c[CELLS].x;
	assign plain.plain_second = data_c[CELLS].y;

endmodule
`default_nettype wire

FILE: src/tbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbd_checker
// Port-level checks for the TEA block decrypt unit, bound to the top level.
// ----------------------------------------------------------------------------
module tbd_checker
	import tbd_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    cipher_stall,
	input wire logic    plain_valid,
	input wire logic    plain_stall,
	input wire plain_t  plain
);

	// a waiting result holds until taken
	a_plain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		plain_valid && plain_stall |=> plain_valid && $stable(plain))
		else $error("plain request changed while stalled");

	// input backs up only when the output is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!plain_valid || !plain_stall |-> !cipher_stall)
		else $error("cipher stalled with free output");

	// reset empties the chain
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !plain_valid)
		else $error("plain valid after reset");

	// no result can leave the chain right after reset release
	a_no_early_out: assert property (@(posedge clk)
		$rose(arst_n) |-> !plain_valid)
		else $error("plain valid right after reset");

endmodule

bind tea_block_decrypt_unit tbd_checker u_tbd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cipher_stall (cipher_stall),
	.plain_valid  (plain_valid),
	.plain_stall  (plain_stall),
	.plain        (plain)
);
`default_nettype wire
